// File: hw/rtl/sliding_window_rate_limiter_defines.svh
// Assertion macros for the sliding window rate limiter.
`ifndef SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH
`define SLIDING_WINDOW_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/swrl_pkg.sv
// Constants shared by the sliding window rate limiter.
package swrl_pkg;

    localparam int NUM_BUCKETS = 10;
    localparam int TS_W        = 40;
    localparam int CNT_W       = 16;
    localparam int BIDX_W      = $clog2(NUM_BUCKETS);
    localparam int STEP_W      = $clog2(TS_W + 1);
    localparam int ADDR_W      = 3;

    localparam logic REG_MAX_REQUESTS = 1'b0;
    localparam logic REG_BUCKET_WIDTH = 1'b1;

    localparam logic [CNT_W-1:0] MAX_REQUESTS_RST = CNT_W'(100);
    localparam logic [CNT_W-1:0] BUCKET_WIDTH_RST = CNT_W'(100);

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

endpackage

// File: hw/rtl/sliding_window_rate_limiter.sv
// Sliding window rate limiter: ring of time buckets with a serial slot divider.
// A request beat goes from acceptance to result through two 40-step restoring
// divisions by the bucket width (last rotation time, then the request timestamp)
// on one shared divider, a compare state, a clear state that empties one stale
// bucket per step (up to NUM_BUCKETS - 1; a gap of a whole window empties all at
// once), a grant state and a result state. A clear beat empties all buckets.
// One beat is in work at a time; the result register frees the input side as
// soon as a result is loaded. A zero bucket width counts as 1 ms.
`include "sliding_window_rate_limiter_defines.svh"

module sliding_window_rate_limiter
    import swrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [TS_W-1:0]   s_axis_tdata,   // [39:0] timestamp_ms
    input  logic              s_axis_tuser,   // [0] kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [CNT_W-1:0]  m_axis_tdata,   // [15:0] window_total
    output logic              m_axis_tuser,   // [0] granted
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_OLD,
        S_DIV_CUR,
        S_CHECK,
        S_CLEAR,
        S_GRANT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_max_req;
    logic [CNT_W-1:0]    r_bucket_w;
    logic [CNT_W-1:0]    r_bucket [NUM_BUCKETS];
    logic [CNT_W-1:0]    r_total;
    logic [TS_W-1:0]     r_last;
    logic [TS_W-1:0]     r_ts;
    logic [TS_W-1:0]     r_dvd;
    logic [CNT_W-1:0]    r_rem;
    logic [BIDX_W-1:0]   r_m10;
    logic [STEP_W-1:0]   r_step;
    logic [TS_W-1:0]     r_old_q;
    logic [BIDX_W-1:0]   r_old_m;
    logic [BIDX_W-1:0]   r_cur_m;
    logic [BIDX_W-1:0]   r_ptr;
    logic [BIDX_W-1:0]   r_left;
    logic                r_grant;
    logic                r_m_valid;
    logic [CNT_W-1:0]    r_m_data;
    logic                r_m_user;

    logic [CNT_W-1:0]    n_width;
    logic [CNT_W:0]      n_trial;
    logic                n_qbit;
    logic [CNT_W-1:0]    n_rem;
    logic [TS_W-1:0]     n_dvd;
    logic [BIDX_W:0]     n_m10_raw;
    logic [BIDX_W-1:0]   n_m10;
    logic [TS_W-1:0]     n_gap;
    logic [BIDX_W-1:0]   n_ptr_inc;
    logic [BIDX_W-1:0]   n_old_inc;
    logic [CNT_W-1:0]    n_sel_cnt;
    logic                w_in_acc;
    logic                w_cfg_wr;
    logic [CNT_W-1:0]    w_bucket_sum;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign prdata        = (paddr[2] == REG_BUCKET_WIDTH) ? {16'b0, r_bucket_w}
                                                          : {16'b0, r_max_req};

    always_comb begin
        n_width   = (r_bucket_w == '0) ? CNT_W'(1) : r_bucket_w;
        n_trial   = {r_rem, r_dvd[TS_W-1]};
        n_qbit    = (n_trial >= {1'b0, n_width});
        n_rem     = n_qbit ? CNT_W'(n_trial - {1'b0, n_width}) : n_trial[CNT_W-1:0];
        n_dvd     = {r_dvd[TS_W-2:0], n_qbit};
        n_m10_raw = {r_m10, n_qbit};
        n_m10     = (n_m10_raw >= (BIDX_W+1)'(NUM_BUCKETS))
                    ? BIDX_W'(n_m10_raw - (BIDX_W+1)'(NUM_BUCKETS))
                    : n_m10_raw[BIDX_W-1:0];
        n_gap     = r_dvd - r_old_q;
        n_ptr_inc = (r_ptr == BIDX_W'(NUM_BUCKETS - 1)) ? '0 : BIDX_W'(r_ptr + 1'b1);
        n_old_inc = (r_old_m == BIDX_W'(NUM_BUCKETS - 1)) ? '0 : BIDX_W'(r_old_m + 1'b1);
        n_sel_cnt = r_bucket[r_ptr];
    end

    always_comb begin
        w_bucket_sum = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            w_bucket_sum = w_bucket_sum + r_bucket[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req  <= MAX_REQUESTS_RST;
            r_bucket_w <= BUCKET_WIDTH_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_MAX_REQUESTS: r_max_req  <= pwdata[CNT_W-1:0];
                REG_BUCKET_WIDTH: r_bucket_w <= pwdata[CNT_W-1:0];
                default:          r_max_req  <= r_max_req;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_last    <= '0;
            r_m_valid <= 1'b0;
            r_grant   <= 1'b0;
            r_ptr     <= '0;
            r_left    <= '0;
            r_step    <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_bucket[i] <= '0;
            end
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ts <= s_axis_tdata;
                        if (s_axis_tuser == KIND_CLEAR) begin
                            for (int i = 0; i < NUM_BUCKETS; i++) begin
                                r_bucket[i] <= '0;
                            end
                            r_total <= '0;
                            r_last  <= s_axis_tdata;
                            r_grant <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_dvd   <= r_last;
                            r_rem   <= '0;
                            r_m10   <= '0;
                            r_step  <= STEP_W'(TS_W);
                            r_state <= S_DIV_OLD;
                        end
                    end
                end
                S_DIV_OLD: begin
                    if (r_step == STEP_W'(1)) begin
                        r_old_q <= n_dvd;
                        r_old_m <= n_m10;
                        r_dvd   <= r_ts;
                        r_rem   <= '0;
                        r_m10   <= '0;
                        r_step  <= STEP_W'(TS_W);
                        r_state <= S_DIV_CUR;
                    end else begin
                        r_dvd  <= n_dvd;
                        r_rem  <= n_rem;
                        r_m10  <= n_m10;
                        r_step <= r_step - 1'b1;
                    end
                end
                S_DIV_CUR: begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_m10  <= n_m10;
                    r_step <= r_step - 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_cur_m <= n_m10;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((r_ts < r_last) || (r_dvd <= r_old_q)) begin
                        r_ptr   <= r_cur_m;
                        r_state <= S_GRANT;
                    end else if (n_gap >= TS_W'(NUM_BUCKETS)) begin
                        for (int i = 0; i < NUM_BUCKETS; i++) begin
                            r_bucket[i] <= '0;
                        end
                        r_total <= '0;
                        r_last  <= r_ts;
                        r_ptr   <= r_cur_m;
                        r_state <= S_GRANT;
                    end else begin
                        r_last  <= r_ts;
                        r_ptr   <= n_old_inc;
                        r_left  <= n_gap[BIDX_W-1:0];
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    r_bucket[r_ptr] <= '0;
                    r_total <= (n_sel_cnt > r_total) ? '0 : CNT_W'(r_total - n_sel_cnt);
                    if (r_left == BIDX_W'(1)) begin
                        r_ptr   <= r_cur_m;
                        r_state <= S_GRANT;
                    end else begin
                        r_ptr  <= n_ptr_inc;
                        r_left <= r_left - 1'b1;
                    end
                end
                S_GRANT: begin
                    if (r_total < r_max_req) begin
                        r_bucket[r_ptr] <= CNT_W'(n_sel_cnt + 1'b1);
                        r_total <= CNT_W'(r_total + 1'b1);
                        r_grant <= 1'b1;
                    end else begin
                        r_grant <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_total;
                        r_m_user  <= r_grant;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SWRL_ASSERT_IMP(a_total_is_sum, r_state == S_IDLE, r_total == w_bucket_sum,
                     "total differs from bucket sum")
    `SWRL_ASSERT_IMP(a_grant_nonzero, m_axis_tvalid && m_axis_tuser, m_axis_tdata != '0,
                     "grant with empty window")
    `SWRL_ASSERT_IMP(a_clear_count, r_state == S_CLEAR,
                     (r_left != '0) && (r_left < BIDX_W'(NUM_BUCKETS)),
                     "stale bucket count out of range")
    `SWRL_ASSERT_NXT(a_req_divides, w_in_acc && (s_axis_tuser == KIND_REQUEST),
                     r_state == S_DIV_OLD, "request did not start division")

endmodule

// File: tb/testbench.sv
// Self-checking bench for the sliding window rate limiter: stream beats, APB set-up, scoreboard.
module testbench;
    import swrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TS_W-1:0] TS_MAX = '1;

    typedef struct packed {
        logic             granted;
        logic [CNT_W-1:0] total;
    } verdict_t;

    class admission_tracker;
        logic [CNT_W-1:0] bucket_cnt [NUM_BUCKETS];
        logic [CNT_W-1:0] window_sum;
        logic [TS_W-1:0]  last_rot;
        logic [CNT_W-1:0] limit_reqs;
        logic [CNT_W-1:0] width_ms;
        verdict_t         verdicts_due [$];
        int               mismatches;
        int               grants;
        int               refusals;
        int               clears;

        function new();
            for (int i = 0; i < NUM_BUCKETS; i++) bucket_cnt[i] = '0;
            window_sum = '0;
            last_rot   = '0;
            limit_reqs = MAX_REQUESTS_RST;
            width_ms   = BUCKET_WIDTH_RST;
            mismatches = 0;
            grants     = 0;
            refusals   = 0;
            clears     = 0;
        endfunction

        function logic [TS_W-1:0] slot_of(logic [TS_W-1:0] ts);
            logic [TS_W-1:0] w;
            w = (width_ms == '0) ? TS_W'(1) : TS_W'(width_ms);
            return ts / w;
        endfunction

        function void drain(int idx);
            logic [CNT_W-1:0] c;
            c = bucket_cnt[idx];
            bucket_cnt[idx] = '0;
            window_sum = (c > window_sum) ? '0 : window_sum - c;
        endfunction

        // empty the window on a clear; else advance the window, then judge the request against the running total
        function void note_beat(logic kind, logic [TS_W-1:0] ts);
            logic [TS_W-1:0] cur_slot;
            logic [TS_W-1:0] old_slot;
            logic [TS_W-1:0] gap;
            verdict_t        v;
            int              b;
            v.granted = 1'b0;
            if (kind == KIND_CLEAR) begin
                for (int i = 0; i < NUM_BUCKETS; i++) bucket_cnt[i] = '0;
                window_sum = '0;
                last_rot   = ts;
                clears++;
            end else begin
                cur_slot = slot_of(ts);
                old_slot = slot_of(last_rot);
                if (ts >= last_rot && cur_slot > old_slot) begin
                    gap = cur_slot - old_slot;
                    if (gap >= NUM_BUCKETS) begin
                        for (int i = 0; i < NUM_BUCKETS; i++) drain(i);
                    end else begin
                        for (int k = 1; k <= int'(gap); k++)
                            drain(int'((old_slot + TS_W'(k)) % NUM_BUCKETS));
                    end
                    last_rot = ts;
                end
                b = int'(cur_slot % NUM_BUCKETS);
                if (window_sum < limit_reqs) begin
                    bucket_cnt[b] = bucket_cnt[b] + 1'b1;
                    window_sum    = window_sum + 1'b1;
                    v.granted     = 1'b1;
                    grants++;
                end else begin
                    refusals++;
                end
            end
            v.total = window_sum;
            verdicts_due.push_back(v);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_verdict(logic granted, logic [CNT_W-1:0] total);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                report($sformatf("unexpected result granted=%0b total=%0d", granted, total));
            end else begin
                v = verdicts_due.pop_front();
                if (granted !== v.granted)
                    report($sformatf("granted %0b, want %0b", granted, v.granted));
                if (total !== v.total)
                    report($sformatf("window_total %0d, want %0d", total, v.total));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [TS_W-1:0]   s_axis_tdata;   // [39:0] timestamp_ms
    logic              s_axis_tuser;   // [0] kind
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [CNT_W-1:0]  m_axis_tdata;   // [15:0] window_total
    logic              m_axis_tuser;   // [0] granted
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    admission_tracker  tracker = new();
    logic [TS_W-1:0]   cur_ts;
    bit                steady;
    int                reg_writes;

    sliding_window_rate_limiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] reg_addr(logic idx);
        return ADDR_W'({idx, 2'b00});
    endfunction

    task automatic send_beat(input logic kind, input logic [TS_W-1:0] ts);
        int pause;
        pause = steady ? 0 : $urandom_range(0, 3);
        if (pause > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_beat(kind, ts);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_reg(input logic idx, input logic [CNT_W-1:0] value);
        logic [31:0] rd;
        apb_write(reg_addr(idx), 32'(value));
        reg_writes++;
        apb_read(reg_addr(idx), rd);
        if (rd[CNT_W-1:0] !== value)
            tracker.report($sformatf("register %0d reads %0d, want %0d", idx, rd, value));
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] max_req, input logic [CNT_W-1:0] width);
        wait_idle();
        program_reg(REG_MAX_REQUESTS, max_req);
        tracker.limit_reqs = max_req;
        program_reg(REG_BUCKET_WIDTH, width);
        tracker.width_ms = width;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_random(input int count);
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] back;
        logic            kind;
        int unsigned     w;
        int              pick;
        int              i;
        for (i = 0; i < count; i++) begin
            w    = (tracker.width_ms == '0) ? 1 : int'(tracker.width_ms);
            pick = $urandom_range(0, 99);
            kind = ($urandom_range(0, 24) == 0) ? KIND_CLEAR : KIND_REQUEST;
            if (pick < 50) begin
                cur_ts = cur_ts + $urandom_range(0, w / 8 + 1);
                ts = cur_ts;
            end else if (pick < 75) begin
                cur_ts = cur_ts + $urandom_range(0, 2 * w);
                ts = cur_ts;
            end else if (pick < 85) begin
                cur_ts = cur_ts + $urandom_range(3 * w, 15 * w);
                ts = cur_ts;
            end else if (pick < 92) begin
                back = TS_W'($urandom_range(1, 3 * w));
                ts = (cur_ts > back) ? cur_ts - back : '0;
            end else if (pick < 96) begin
                cur_ts = {8'($urandom_range(0, 255)), 32'($urandom())};
                ts = cur_ts;
            end else begin
                cur_ts = TS_MAX - TS_W'($urandom_range(0, 3 * w));
                ts = cur_ts;
            end
            send_beat(kind, ts);
            if ($urandom_range(0, 199) == 0) steady = ~steady;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_REQUEST;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cur_ts         = '0;
        steady         = 1'b0;
        reg_writes     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(KIND_REQUEST, 40'd0);
        send_beat(KIND_REQUEST, 40'd0);
        send_beat(KIND_REQUEST, 40'd99);
        send_beat(KIND_REQUEST, 40'd100);
        send_beat(KIND_REQUEST, 40'd550);
        send_beat(KIND_REQUEST, 40'd50);
        send_beat(KIND_REQUEST, 40'd1499);
        send_beat(KIND_REQUEST, 40'd2600);
        send_beat(KIND_CLEAR,   40'd3000);
        send_beat(KIND_REQUEST, 40'd3000);
        send_beat(KIND_REQUEST, TS_MAX);
        send_beat(KIND_REQUEST, 40'd0);
        send_beat(KIND_CLEAR,   TS_MAX);
        send_beat(KIND_REQUEST, TS_MAX);

        set_limits(16'd2, 16'd1);
        send_beat(KIND_CLEAR,   40'd0);
        send_beat(KIND_REQUEST, 40'd5);
        send_beat(KIND_REQUEST, 40'd5);
        send_beat(KIND_REQUEST, 40'd5);
        send_beat(KIND_REQUEST, 40'd6);
        send_beat(KIND_REQUEST, 40'd16);

        set_limits(16'd0, 16'd0);
        send_beat(KIND_REQUEST, 40'd17);
        send_beat(KIND_REQUEST, 40'd40);

        set_limits(16'hFFFF, 16'hFFFF);
        send_beat(KIND_REQUEST, 40'h00_0001_0000);
        send_beat(KIND_REQUEST, 40'h55_5555_5555);
        cur_ts = 40'h55_5555_5555;

        run_random(170);
        set_limits(16'd1, 16'd1);
        run_random(170);
        set_limits(16'd3, 16'd10);
        run_random(170);
        set_limits(MAX_REQUESTS_RST, BUCKET_WIDTH_RST);
        run_random(170);
        set_limits(16'd0, 16'd7);
        run_random(170);
        set_limits(16'd5, 16'd0);
        run_random(170);
        repeat (3) begin
            set_limits(CNT_W'($urandom_range(1, 20)), CNT_W'($urandom_range(1, 500)));
            run_random(170);
        end
        set_limits(CNT_W'($urandom()), CNT_W'($urandom()));
        run_random(170);

        wait_idle();
        repeat (100) @(posedge i_clk);
        $display("beats: %0d granted, %0d refused, %0d clears; %0d register writes",
                 tracker.grants, tracker.refusals, tracker.clears, reg_writes);
        $display("settings swept from zero limit and width up to full scale");
        if (tracker.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        int hold;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            tracker.check_verdict(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
